FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, clocked on clk, disabled while rst_n is low.
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/he_pkg.sv
`timescale 1ns / 1ps

package he_pkg;

    localparam int PIX_W    = 8;
    localparam int LEVELS   = 1 << PIX_W;
    localparam int IDX_W    = PIX_W + 1;
    localparam int DIV_STEPS = PIX_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_COUNT    = 2'd1,
        CMD_FINALIZE = 2'd2,
        CMD_MAP      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_MAP_LD,
        S_MAP_DIV
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // word accepted: latch pixel, read its bin
        logic clear;
        logic count_wr;
        logic scan_start;
        logic scan_step;
        logic map_load;
        logic div_step;
        logic finish;      // write result registers
        logic err;
        logic grey_sel;    // result carries the quotient
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic finalized;
        logic total_zero;
        logic scan_last;
        logic div_last;
    } t_dp_stat;

endpackage

FILE: rtl/histogram_equalizer.sv
// Count reads the pixel's bin, then writes it back with a saturating increment; map runs a
// restoring divider over the pixel total, one quotient bit per cycle; finalize walks all
// 256 bins through the single read/write bin memory. New commands are taken only while idle.
// Each result shows on o_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the histogram (bin valid bits cleared) at once.
`timescale 1ns / 1ps

module histogram_equalizer #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [1:0]               i_command,
    input  logic [he_pkg::PIX_W-1:0] i_pixel_value,
    output logic                     busy,
    output logic                     o_valid,
    output logic [he_pkg::PIX_W-1:0] o_grey_out,
    output logic                     o_status
);

    he_pkg::t_dp_cmd  w_cmd;
    he_pkg::t_dp_stat w_stat;

    he_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .busy      (busy)
    );

    he_dp #(
        .CW (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_value (i_pixel_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_grey_out    (o_grey_out),
        .o_status      (o_status)
    );

endmodule

FILE: rtl/he_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module he_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_command,
    input  he_pkg::t_dp_stat i_stat,
    output he_pkg::t_dp_cmd  o_cmd,
    output logic             busy
);

    he_pkg::t_state r_state, n_state;
    he_pkg::t_cmd   w_cmd;

    assign w_cmd = he_pkg::t_cmd'(i_command);
    assign busy  = (r_state != he_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= he_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            he_pkg::S_IDLE: begin
                if (start) begin
                    unique case (w_cmd)
                        he_pkg::CMD_CLEAR:    n_state = he_pkg::S_IDLE;
                        he_pkg::CMD_COUNT: begin
                            if (!i_stat.finalized) n_state = he_pkg::S_COUNT;
                        end
                        he_pkg::CMD_FINALIZE: begin
                            if (!i_stat.finalized) n_state = he_pkg::S_SCAN;
                        end
                        he_pkg::CMD_MAP: begin
                            if (i_stat.finalized && !i_stat.total_zero)
                                n_state = he_pkg::S_MAP_LD;
                        end
                        default: n_state = he_pkg::S_IDLE;
                    endcase
                end
            end
            he_pkg::S_COUNT:  n_state = he_pkg::S_IDLE;
            he_pkg::S_SCAN: begin
                if (i_stat.scan_last) n_state = he_pkg::S_IDLE;
            end
            he_pkg::S_MAP_LD: n_state = he_pkg::S_MAP_DIV;
            he_pkg::S_MAP_DIV: begin
                if (i_stat.div_last) n_state = he_pkg::S_IDLE;
            end
            default: n_state = he_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            he_pkg::S_IDLE: begin
                o_cmd.load = start;
                if (start) begin
                    unique case (w_cmd)
                        he_pkg::CMD_CLEAR: begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.finish = 1'b1;
                        end
                        he_pkg::CMD_COUNT: begin
                            if (i_stat.finalized) begin
                                o_cmd.finish = 1'b1;
                                o_cmd.err    = 1'b1;
                            end
                        end
                        he_pkg::CMD_FINALIZE: begin
                            if (i_stat.finalized) begin
                                o_cmd.finish = 1'b1;
                                o_cmd.err    = 1'b1;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                            end
                        end
                        he_pkg::CMD_MAP: begin
                            if (!i_stat.finalized || i_stat.total_zero) begin
                                o_cmd.finish = 1'b1;
                                o_cmd.err    = 1'b1;
                            end
                        end
                        default: o_cmd.finish = 1'b0;
                    endcase
                end
            end
            he_pkg::S_COUNT: begin
                o_cmd.count_wr = 1'b1;
                o_cmd.finish   = 1'b1;
            end
            he_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.finish    = i_stat.scan_last;
            end
            he_pkg::S_MAP_LD: begin
                o_cmd.map_load = 1'b1;
            end
            he_pkg::S_MAP_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.finish   = i_stat.div_last;
                o_cmd.grey_sel = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    `ASSERT_NEVER(a_scan_when_final, i_clk, i_rst_n, (r_state == he_pkg::S_SCAN) && i_stat.finalized)
    `ASSERT_PROP(a_map_needs_hist, i_clk, i_rst_n, (r_state == he_pkg::S_MAP_LD) |-> (i_stat.finalized && !i_stat.total_zero))
    `ASSERT_PROP(a_count_one_cycle, i_clk, i_rst_n, (r_state == he_pkg::S_COUNT) |=> (r_state == he_pkg::S_IDLE))
    `ASSERT_PROP(a_finish_to_idle, i_clk, i_rst_n, (o_cmd.finish && busy) |=> (r_state == he_pkg::S_IDLE))

endmodule

FILE: rtl/he_dp.sv
`timescale 1ns / 1ps

module he_dp #(
    parameter int CW = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [he_pkg::PIX_W-1:0] i_pixel_value,
    input  he_pkg::t_dp_cmd          i_cmd,
    output he_pkg::t_dp_stat         o_stat,
    output logic                     o_valid,
    output logic [he_pkg::PIX_W-1:0] o_grey_out,
    output logic                     o_status
);

    localparam int PW = he_pkg::PIX_W;
    localparam int NW = CW + PW;

    logic [CW-1:0]   r_mem [he_pkg::LEVELS];
    logic            r_vld [he_pkg::LEVELS];

    logic [CW-1:0]   r_rd_data;
    logic            r_rd_ok;
    logic [PW-1:0]   r_pix;
    logic [CW-1:0]   r_total;
    logic            r_finalized;

    logic [he_pkg::IDX_W-1:0] r_idx;
    logic [PW-1:0]   r_wr_idx;
    logic            r_rd_vld;
    logic [CW-1:0]   r_run;

    logic [CW-1:0]   r_rem;
    logic [PW-1:0]   r_low;
    logic [PW-1:0]   r_q;
    logic [he_pkg::STEP_W-1:0] r_step;

    logic            r_valid;
    logic [PW-1:0]   r_grey;
    logic            r_status;

    logic [CW-1:0]   w_bin;
    logic            w_rd_en;
    logic [PW-1:0]   w_rd_addr;
    logic            w_wr_en;
    logic [PW-1:0]   w_wr_addr;
    logic [CW-1:0]   w_wr_data;
    logic [CW:0]     w_run_sum;
    logic [NW-1:0]   w_num;
    logic [CW:0]     w_trial;
    logic            w_qbit;
    logic [PW-1:0]   w_q_next;
    logic            w_scan_last;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        sat_inc = (v == {CW{1'b1}}) ? v : v + {{(CW-1){1'b0}}, 1'b1};
    endfunction

    assign w_bin       = r_rd_ok ? r_rd_data : '0;
    assign w_scan_last = r_idx[he_pkg::IDX_W-1] && r_rd_vld;

    assign w_rd_en   = i_cmd.load || (i_cmd.scan_step && !r_idx[he_pkg::IDX_W-1]);
    assign w_rd_addr = i_cmd.scan_step ? r_idx[PW-1:0] : i_pixel_value;

    assign w_run_sum = {1'b0, r_run} + {1'b0, w_bin};

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pix;
        w_wr_data = sat_inc(w_bin);
        if (i_cmd.count_wr) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.scan_step && r_rd_vld) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_wr_idx;
            w_wr_data = r_run;
        end
    end

    // 255 * c as (c << 8) - c
    assign w_num = {w_bin, {PW{1'b0}}} - {{PW{1'b0}}, w_bin};

    assign w_trial  = {r_rem, r_low[PW-1]};
    assign w_qbit   = (w_trial >= {1'b0, r_total});
    assign w_q_next = {r_q[PW-2:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_ok   <= r_vld[w_rd_addr];
        end
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < he_pkg::LEVELS; i++) r_vld[i] <= 1'b0;
        end else if (i_cmd.clear) begin
            for (int i = 0; i < he_pkg::LEVELS; i++) r_vld[i] <= 1'b0;
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_finalized <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_idx       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_total     <= '0;
                r_finalized <= 1'b0;
            end else if (i_cmd.count_wr) begin
                r_total <= sat_inc(r_total);
            end else if (i_cmd.scan_step && w_scan_last) begin
                r_finalized <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= !r_idx[he_pkg::IDX_W-1];
                if (!r_idx[he_pkg::IDX_W-1]) r_idx <= r_idx + 1'b1;
            end
        end
    end

    // scan pipeline, divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_pix <= i_pixel_value;
        if (i_cmd.scan_start) begin
            r_run <= '0;
        end else if (i_cmd.scan_step) begin
            r_wr_idx <= r_idx[PW-1:0];
            if (r_rd_vld) r_run <= w_run_sum[CW] ? {CW{1'b1}} : w_run_sum[CW-1:0];
        end
        if (i_cmd.map_load) begin
            r_rem  <= w_num[NW-1:PW];
            r_low  <= w_num[PW-1:0];
            r_q    <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? (w_trial[CW-1:0] - r_total) : w_trial[CW-1:0];
            r_low  <= {r_low[PW-2:0], 1'b0};
            r_q    <= w_q_next;
            r_step <= r_step + 1'b1;
        end
        if (i_cmd.finish) begin
            r_grey   <= i_cmd.grey_sel ? w_q_next : '0;
            r_status <= i_cmd.err;
        end
    end

    assign o_stat.finalized  = r_finalized;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.scan_last  = w_scan_last;
    assign o_stat.div_last   = (r_step == he_pkg::STEP_W'(he_pkg::DIV_STEPS - 1));

    assign o_valid    = r_valid;
    assign o_grey_out = r_grey;
    assign o_status   = r_status;

endmodule
